// ===== design/assert_macros.svh =====
// Assertion macros shared by the dual-window change trigger RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DWM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define DWM_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DWM_ASSERT(lbl, clk, rst_n, prop)
`define DWM_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== design/dwmct_pkg.sv =====
// Shared types and constants of the dual-window change trigger.
package dwmct_pkg;

    localparam int CMD_W      = 2;
    localparam int SAMPLE_W   = 10;
    localparam int MEAN_W     = 10;
    localparam int THRESH_W   = 10;
    localparam int INTERVAL_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ARM    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISARM = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_INTERVAL = 1'd1;

    localparam logic [THRESH_W-1:0]   THRESH_RST   = 10'd20;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd50;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [SAMPLE_W-1:0] sample;
    } t_in_req;

    typedef struct packed {
        logic              fired;
        logic              is_armed;
        logic [MEAN_W-1:0] short_mean;
        logic [MEAN_W-1:0] long_mean;
    } t_out_req;

    typedef struct packed {
        logic fill;
        logic push;
    } t_ring_ctl;

endpackage

// ===== design/dwmct_cell.sv =====
// One sample cell of a ring: parallel fill or shift from its neighbor.
module dwmct_cell import dwmct_pkg::*; #(
    parameter int SB = 10
) (
    input  logic          i_clk,
    input  t_ring_ctl     i_ctl,
    input  logic [SB-1:0] i_sample,
    input  logic [SB-1:0] i_prev,
    output logic [SB-1:0] o_q
);

    logic [SB-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.fill) begin
            r_q <= i_sample;
        end else if (i_ctl.push) begin
            r_q <= i_prev;
        end
    end

    assign o_q = r_q;

endmodule

// ===== design/dwmct_ring.sv =====
// Sample ring as a chain of cells with its running total.
module dwmct_ring import dwmct_pkg::*; #(
    parameter int LEN = 8,
    parameter int SB  = 10,
    localparam int TW = SB + $clog2(LEN)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ring_ctl     i_ctl,
    input  logic [SB-1:0] i_sample,
    output logic [TW-1:0] o_total
);

    logic [SB-1:0] w_q    [LEN];
    logic [SB-1:0] w_prev [LEN];
    logic [TW-1:0] r_total;

    assign w_prev[0] = i_sample;

    for (genvar k = 0; k < LEN; k++) begin : g_cell
        if (k > 0) begin : g_link
            assign w_prev[k] = w_q[k-1];
        end
        dwmct_cell #(.SB(SB)) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (i_ctl),
            .i_sample (i_sample),
            .i_prev   (w_prev[k]),
            .o_q      (w_q[k])
        );
    end

    // oldest sample sits in the last cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_ctl.fill) begin
            r_total <= TW'(i_sample) * TW'(LEN);
        end else if (i_ctl.push) begin
            r_total <= r_total - TW'(w_q[LEN-1]) + TW'(i_sample);
        end
    end

    assign o_total = r_total;

endmodule

// ===== design/dwmct_div.sv =====
// Ring mean: reciprocal multiplication of a ring total by its length, registered on start.
module dwmct_div #(
    parameter int LEN = 8,
    parameter int SB  = 10,
    localparam int TW = SB + $clog2(LEN)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [TW-1:0] i_dividend,
    output logic [SB-1:0] o_quo,
    output logic          o_done
);

    localparam int SH = TW + $clog2(LEN);
    localparam int MW = TW + 1;
    localparam int PW = TW + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(LEN) - 64'd1) / 64'(LEN));

    logic          r_done;
    logic [SB-1:0] r_quo;
    logic [PW-1:0] w_prod;

    // exact floor for every total below 2**TW
    assign w_prod = PW'(i_dividend) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= SB'(w_prod >> SH);
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

// ===== design/dual_window_mean_change_trigger.sv =====
// Top level of the dual-window mean change trigger.
//
//   channel   dir  handshake                 payload
//   input     in   i_in_valid / o_in_stall   i_in_req  (t_in_req)
//   result    out  o_out_valid / i_out_stall o_out_req (t_out_req)
//   config    in   i_cfg_we                  i_cfg_idx, i_cfg_data
//
// Arm, disarm, non-frame ticks and unused commands: the result is registered at acceptance.
// A frame tick passes through ST_IDLE, ST_START, ST_DIV and ST_CMP: ring shift at acceptance,
//   reciprocal multiply of both totals into the means, hand-off, then the threshold compare.
// Reset is synchronous; the ring cells hold no reset and are only read after an arm fill.
// A stalled result holds the output register; no new request is taken until it can move.
`include "assert_macros.svh"
module dual_window_mean_change_trigger import dwmct_pkg::*; #(
    parameter int FIRST_LEN   = 8,
    parameter int SECOND_LEN  = 64,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_req               i_in_req,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_req              o_out_req,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SB     = SAMPLE_BITS;
    localparam int TW1    = SB + $clog2(FIRST_LEN);
    localparam int TW2    = SB + $clog2(SECOND_LEN);
    localparam int CW     = (SB > THRESH_W) ? SB : THRESH_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_CMP   = 4'b1000
    } t_state;

    t_state                r_state;
    logic                  r_armed;
    logic [INTERVAL_W-1:0] r_elapsed;
    logic [THRESH_W-1:0]   r_thresh;
    logic [INTERVAL_W-1:0] r_interval;
    logic [SB-1:0]         r_short_mean;
    logic [SB-1:0]         r_long_mean;
    logic                  r_out_valid;
    t_out_req              r_out;

    logic                  w_in_acc;
    logic                  w_out_free;
    logic [SB-1:0]         w_sample;
    logic [INTERVAL_W-1:0] n_elapsed;
    logic                  w_frame;
    t_ring_ctl             w_ring_ctl;
    logic [TW1-1:0]        w_short_total;
    logic [TW2-1:0]        w_long_total;
    logic [SB-1:0]         w_short_quo;
    logic [SB-1:0]         w_long_quo;
    logic                  w_short_done;
    logic                  w_long_done;
    logic                  w_div_start;
    logic [SB-1:0]         w_diff;
    logic                  w_fired;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && w_out_free);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_sample   = SB'(i_in_req.sample);

    always_comb begin
        n_elapsed = (r_elapsed != '1) ? r_elapsed + 1'b1 : r_elapsed;
        w_frame   = (i_in_req.cmd == CMD_TICK) && r_armed && (n_elapsed >= r_interval);
        w_ring_ctl.fill = w_in_acc && (i_in_req.cmd == CMD_ARM);
        w_ring_ctl.push = w_in_acc && w_frame;
        w_div_start     = (r_state == ST_START);
        w_diff  = (w_short_quo > w_long_quo) ? w_short_quo - w_long_quo
                                             : w_long_quo - w_short_quo;
        w_fired = CW'(w_diff) > CW'(r_thresh);
    end

    dwmct_ring #(.LEN(FIRST_LEN), .SB(SB)) u_short_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ring_ctl),
        .i_sample (w_sample),
        .o_total  (w_short_total)
    );

    dwmct_ring #(.LEN(SECOND_LEN), .SB(SB)) u_long_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ring_ctl),
        .i_sample (w_sample),
        .o_total  (w_long_total)
    );

    dwmct_div #(.LEN(FIRST_LEN), .SB(SB)) u_short_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_short_total),
        .o_quo      (w_short_quo),
        .o_done     (w_short_done)
    );

    dwmct_div #(.LEN(SECOND_LEN), .SB(SB)) u_long_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_long_total),
        .o_quo      (w_long_quo),
        .o_done     (w_long_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh   <= THRESH_RST;
            r_interval <= INTERVAL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THRESHOLD:      r_thresh   <= i_cfg_data[THRESH_W-1:0];
                REG_FRAME_INTERVAL: r_interval <= i_cfg_data[INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_armed      <= 1'b0;
            r_elapsed    <= '0;
            r_short_mean <= '0;
            r_long_mean  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        case (i_in_req.cmd)
                            CMD_ARM: begin
                                r_armed      <= 1'b1;
                                r_elapsed    <= '0;
                                r_short_mean <= w_sample;
                                r_long_mean  <= w_sample;
                                r_out_valid  <= 1'b1;
                                r_out        <= '{1'b0, 1'b1, MEAN_W'(w_sample),
                                                  MEAN_W'(w_sample)};
                            end
                            CMD_DISARM: begin
                                r_armed     <= 1'b0;
                                r_out_valid <= 1'b1;
                                r_out       <= '{1'b0, 1'b0, MEAN_W'(r_short_mean),
                                                 MEAN_W'(r_long_mean)};
                            end
                            default: begin
                                if ((i_in_req.cmd == CMD_TICK) && r_armed) begin
                                    r_elapsed <= w_frame ? '0 : n_elapsed;
                                end
                                if (w_frame) begin
                                    r_state <= ST_START;
                                end else begin
                                    r_out_valid <= 1'b1;
                                    r_out       <= '{1'b0, r_armed, MEAN_W'(r_short_mean),
                                                     MEAN_W'(r_long_mean)};
                                end
                            end
                        endcase
                    end
                end
                ST_START: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_short_done) begin
                        r_state <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    if (w_out_free) begin
                        r_short_mean <= w_short_quo;
                        r_long_mean  <= w_long_quo;
                        r_armed      <= !w_fired;
                        r_out_valid  <= 1'b1;
                        r_out        <= '{w_fired, !w_fired, MEAN_W'(w_short_quo),
                                          MEAN_W'(w_long_quo)};
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    `DWM_ASSERT(a_div_lockstep, i_clk, i_rst_n, (r_state == ST_DIV) |-> (w_short_done == w_long_done))
    `DWM_ASSERT(a_div_to_cmp, i_clk, i_rst_n, (r_state == ST_DIV && w_short_done) |=> (r_state == ST_CMP))
    `DWM_ASSERT(a_cmp_result, i_clk, i_rst_n, (r_state == ST_CMP && w_out_free) |=> (r_state == ST_IDLE && r_out_valid))
    `DWM_ASSERT(a_frame_needs_arm, i_clk, i_rst_n, w_ring_ctl.push |-> r_armed)
    `DWM_ASSERT_NR(a_fire_disarms, i_clk, r_out_valid |-> !(r_out.fired && r_out.is_armed))

endmodule

// ===== sim/dwmct_tb_pkg.sv =====
// Scoreboard class that predicts and checks the mean change trigger results.
package dwmct_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;
    import dwmct_pkg::*;

    localparam int SHORT_LEN = 8;
    localparam int LONG_LEN  = 64;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [15:0] ELAPSED_SAT = 16'hFFFF;

    class mean_change_scoreboard;
        logic [SAMPLE_W-1:0]   short_ring[SHORT_LEN];
        logic [SAMPLE_W-1:0]   long_ring[LONG_LEN];
        int                    short_head;
        int                    long_head;
        int                    short_sum;
        int                    long_sum;
        bit                    armed;
        logic [15:0]           elapsed;
        logic [THRESH_W-1:0]   thresh;
        logic [INTERVAL_W-1:0] interval;
        t_out_req              expected_q[$];
        int                    errors;
        int                    requests;
        int                    frames;
        int                    triggers;
        int                    checked;

        function new();
            foreach (short_ring[i]) short_ring[i] = '0;
            foreach (long_ring[i]) long_ring[i] = '0;
            short_head = 0;
            long_head  = 0;
            short_sum  = 0;
            long_sum   = 0;
            armed      = 0;
            elapsed    = '0;
            thresh     = THRESH_RST;
            interval   = INTERVAL_RST;
            errors     = 0;
            requests   = 0;
            frames     = 0;
            triggers   = 0;
            checked    = 0;
        endfunction

        function int short_mean();
            return short_sum / SHORT_LEN;
        endfunction

        function int long_mean();
            return long_sum / LONG_LEN;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(t_in_req r);
            t_out_req want;
            int       diff;
            bit       hit;
            hit = 0;
            requests++;
            case (r.cmd)
                CMD_ARM: begin
                    foreach (short_ring[i]) short_ring[i] = r.sample;
                    foreach (long_ring[i]) long_ring[i] = r.sample;
                    short_head = 0;
                    long_head  = 0;
                    short_sum  = int'(r.sample) * SHORT_LEN;
                    long_sum   = int'(r.sample) * LONG_LEN;
                    elapsed    = '0;
                    armed      = 1;
                end
                CMD_DISARM: begin
                    armed = 0;
                end
                CMD_TICK: begin
                    if (armed) begin
                        if (elapsed != ELAPSED_SAT) elapsed++;
                        if (elapsed >= interval) begin
                            elapsed = '0;
                            frames++;
                            short_sum = short_sum - int'(short_ring[short_head]) + int'(r.sample);
                            short_ring[short_head] = r.sample;
                            short_head = (short_head + 1) % SHORT_LEN;
                            long_sum = long_sum - int'(long_ring[long_head]) + int'(r.sample);
                            long_ring[long_head] = r.sample;
                            long_head = (long_head + 1) % LONG_LEN;
                            diff = short_mean() - long_mean();
                            if (diff < 0) diff = -diff;
                            if (diff > int'(thresh)) begin
                                hit   = 1;
                                armed = 0;
                                triggers++;
                            end
                        end
                    end
                end
                default: ;
            endcase
            want.fired      = hit;
            want.is_armed   = armed;
            want.short_mean = MEAN_W'(short_mean());
            want.long_mean  = MEAN_W'(long_mean());
            expected_q.push_back(want);
        endfunction

        function void report(string field, int want, logic [MEAN_W-1:0] got, longint now);
            errors++;
            if (errors <= 30)
                $display("%0t ns: %s expected %0d, got %0d", now, field, want, got);
        endfunction

        function void check_result(t_out_req got, longint now);
            t_out_req want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t ns: result with nothing pending, got %h", now, got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.fired !== want.fired) report("fired", want.fired, got.fired, now);
            if (got.is_armed !== want.is_armed)
                report("is_armed", want.is_armed, got.is_armed, now);
            if (got.short_mean !== want.short_mean)
                report("short_mean", want.short_mean, got.short_mean, now);
            if (got.long_mean !== want.long_mean)
                report("long_mean", want.long_mean, got.long_mean, now);
        endfunction
    endclass

endpackage

// ===== sim/dual_window_mean_change_trigger_tb.sv =====
// Testbench of the dual-window mean change trigger: directed and random traffic against a scoreboard.
module dual_window_mean_change_trigger_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dwmct_pkg::*;
    import dwmct_tb_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    t_in_req               i_in_req = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_req              o_out_req;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    mean_change_scoreboard sb = new();
    bit calm = 1'b0;
    int stall_left = 0;
    int level = 512;
    int idle_cycles = 0;

    dual_window_mean_change_trigger uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            if (!calm && $urandom_range(0, 2) == 0) stall_left <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            sb.check_result(o_out_req, $time);
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("no progress for %0d cycles", IDLE_LIMIT);
        $display("dual_window_mean_change_trigger: mismatch");
        $finish;
    end

    task automatic push_request(input logic [CMD_W-1:0] cmd, input int value);
        t_in_req r;
        int      g;
        r.cmd    = cmd;
        r.sample = SAMPLE_W'(value);
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.note_request(r);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // block must be idle: call after drain
    task automatic configure(input logic [THRESH_W-1:0] thr,
                             input logic [INTERVAL_W-1:0] intv);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_THRESHOLD;
        i_cfg_data <= CFG_DATA_W'(thr);
        @(posedge i_clk);
        sb.thresh = thr;
        i_cfg_idx  <= REG_FRAME_INTERVAL;
        i_cfg_data <= intv;
        @(posedge i_clk);
        sb.interval = intv;
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [THRESH_W-1:0] thr,
                             input logic [INTERVAL_W-1:0] intv,
                             input int count, input bit quiet);
        int               done;
        int               r;
        int               value;
        logic [CMD_W-1:0] cmd;
        done = 0;
        drain();
        configure(thr, intv);
        calm = quiet;
        while (done < count) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 15) level = $urandom_range(0, 1023);
            value = level + $urandom_range(0, 16) - 8;
            if (value < 0) value = 0;
            if (value > 1023) value = 1023;
            if (!sb.armed) begin
                if (r < 80) cmd = CMD_ARM;
                else if (r < 90) cmd = CMD_TICK;
                else if (r < 95) cmd = CMD_DISARM;
                else cmd = CMD_UNUSED;
            end else begin
                if (r < 88) cmd = CMD_TICK;
                else if (r < 92) cmd = CMD_ARM;
                else if (r < 95) cmd = CMD_DISARM;
                else if (r < 97) cmd = CMD_UNUSED;
                else begin
                    cmd   = CMD_TICK;
                    value = $urandom_range(0, 1023);
                end
            end
            push_request(cmd, value);
            done++;
            if ($urandom_range(0, 59) == 0) drain();
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle block, reset settings, zero means
        push_request(CMD_TICK, 1023);
        push_request(CMD_UNUSED, 'h155);
        push_request(CMD_DISARM, 'h2AA);
        drain();
        configure(10'd0, 16'd0);
        push_request(CMD_ARM, 1023);
        push_request(CMD_TICK, 0);
        push_request(CMD_TICK, 5);
        push_request(CMD_ARM, 0);
        push_request(CMD_TICK, 1023);
        push_request(CMD_ARM, 512);
        push_request(CMD_ARM, 300);
        push_request(CMD_TICK, 300);
        push_request(CMD_UNUSED, 'h2AA);
        push_request(CMD_DISARM, 0);
        push_request(CMD_DISARM, 0);
        drain();
        configure(10'd1023, 16'd2);
        push_request(CMD_ARM, 1023);
        push_request(CMD_TICK, 0);
        push_request(CMD_TICK, 0);
        push_request(CMD_TICK, 0);
        push_request(CMD_TICK, 0);

        run_phase(10'd0, 16'd0, 80, 1'b0);
        run_phase(10'd1023, 16'd0, 60, 1'b0);
        run_phase(THRESH_RST, INTERVAL_RST, 60, 1'b0);
        run_phase(10'd8, 16'd1, 100, 1'b1);
        run_phase(10'd30, 16'd2, 100, 1'b0);
        run_phase(10'd1023, 16'd65535, 20, 1'b0);
        run_phase(10'd4, 16'd3, 100, 1'b1);
        repeat (3) begin
            run_phase(THRESH_W'($urandom_range(0, 60)), INTERVAL_W'($urandom_range(0, 4)),
                      60, 1'b0);
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0d expected results never arrived", sb.pending());
        end
        $display("run: %0d requests, %0d frames, %0d triggers, %0d results checked",
                 sb.requests, sb.frames, sb.triggers, sb.checked);
        $display("thresholds 0 to 1023, frame intervals 0 to 65535, random back-pressure");
        if (sb.errors == 0) begin
            $display("dual_window_mean_change_trigger: match");
        end else begin
            $display("dual_window_mean_change_trigger: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/dwmct_pkg.sv
design/dwmct_cell.sv
design/dwmct_ring.sv
design/dwmct_div.sv
design/dual_window_mean_change_trigger.sv
sim/dwmct_tb_pkg.sv
sim/dual_window_mean_change_trigger_tb.sv
